FILE: src/sfm_pkg.sv
`timescale 1ns / 1ps

package sfm_pkg;

  // Needle storage is fixed by the two 64-bit configuration registers.
  localparam int NEEDLE_BYTES = 16;
  localparam int LEN_W        = 5;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int OUT_POS_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN  = 2'd2;

  typedef logic [NEEDLE_BYTES-1:0][7:0] needle_t;

  // Control broadcast from the top level to every cell of the window.
  typedef struct packed {
    logic             shift;
    logic             clear;
    logic [LEN_W-1:0] len;
  } cell_ctrl_t;

endpackage

FILE: src/sfm_cell.sv
`timescale 1ns / 1ps

module sfm_cell #(
  parameter int K = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfm_pkg::cell_ctrl_t ctrl,
  input  sfm_pkg::needle_t   needle,
  input  logic [7:0]         byte_in,
  output logic [7:0]         byte_out,
  output logic               ok
);

  logic [7:0]               byte_r;
  logic [7:0]               byte_nxt;
  logic [3:0]               idx;
  logic                     active;

  always_comb begin
    if (ctrl.clear) begin
      byte_nxt = 8'd0;
    end else if (ctrl.shift) begin
      byte_nxt = byte_in;
    end else begin
      byte_nxt = byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // After the shift this cell holds byte_in, which lines up with needle
  // byte len-1-K. Cells beyond the needle length always agree.
  assign active   = ctrl.len > sfm_pkg::LEN_W'(K);
  assign idx      = 4'(ctrl.len - sfm_pkg::LEN_W'(1) - sfm_pkg::LEN_W'(K));
  assign ok       = !active || (byte_in == needle[idx]);
  assign byte_out = byte_r;

endmodule

FILE: src/substring_first_match.sv
`timescale 1ns / 1ps

// Streaming first-match substring search. Haystack bytes arrive one item
// per clock; a zero byte ends the string. The window of recent bytes is a
// row of MAX_NEEDLE cells that shift in step, each comparing its byte with
// the matching needle byte; the result that an item causes is registered as
// the item is accepted and shows in the next cycle. The block accepts a
// new item each cycle unless a result is waiting that the consumer has not
// taken. One result per string: found with the start offset, or not found
// at the terminating zero; after a result, bytes up to the zero are dropped.
// The user must write the needle (up to sixteen bytes) and its length only
// while the block is idle; the block itself does not enforce this.
module substring_first_match #(
  parameter int MAX_NEEDLE     = 16,
  parameter int POSITION_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_haystack_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [sfm_pkg::OUT_POS_W-1:0]       out_match_position,
  input  logic                                cfg_we,
  input  logic [sfm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int PW = POSITION_WIDTH;
  localparam int CW = (PW > sfm_pkg::LEN_W) ? PW : sfm_pkg::LEN_W;
  localparam logic [PW-1:0] COUNT_MAX = {PW{1'b1}};

  logic [sfm_pkg::CFG_DATA_W-1:0] needle_lo_r;
  logic [sfm_pkg::CFG_DATA_W-1:0] needle_hi_r;
  logic [sfm_pkg::LEN_W-1:0]      needle_len_r;
  sfm_pkg::needle_t               needle;
  logic [sfm_pkg::LEN_W-1:0]      len;

  logic [PW-1:0] count_r, count_nxt;
  logic          given_r, given_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic [sfm_pkg::OUT_POS_W-1:0] out_pos_r, out_pos_nxt;

  logic                  accept;
  logic                  is_zero;
  logic                  checked;
  logic                  hit;
  logic [PW-1:0]         pos;
  logic [CW-1:0]         diff;
  sfm_pkg::cell_ctrl_t   ctrl;
  logic [7:0]            window [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] cell_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_lo_r  <= '0;
      needle_hi_r  <= '0;
      needle_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfm_pkg::CFG_NEEDLE_LOW:  needle_lo_r  <= cfg_wdata;
        sfm_pkg::CFG_NEEDLE_HIGH: needle_hi_r  <= cfg_wdata;
        sfm_pkg::CFG_NEEDLE_LEN:  needle_len_r <= cfg_wdata[sfm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign needle = {needle_hi_r, needle_lo_r};
  assign len    = (needle_len_r > sfm_pkg::LEN_W'(MAX_NEEDLE)) ?
                  sfm_pkg::LEN_W'(MAX_NEEDLE) : needle_len_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_zero  = (in_haystack_byte == 8'd0);

  assign ctrl.len   = len;
  assign ctrl.clear = accept && is_zero;
  assign ctrl.shift = accept && !is_zero && !given_r && (len != '0);

  genvar g;
  generate
    for (g = 0; g < MAX_NEEDLE; g++) begin : g_cell
      if (g == 0) begin : g_head
        sfm_cell #(.K(g)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .ctrl     (ctrl),
          .needle   (needle),
          .byte_in  (in_haystack_byte),
          .byte_out (window[g]),
          .ok       (cell_ok[g])
        );
      end else begin : g_body
        sfm_cell #(.K(g)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .ctrl     (ctrl),
          .needle   (needle),
          .byte_in  (window[g-1]),
          .byte_out (window[g]),
          .ok       (cell_ok[g])
        );
      end
    end
  endgenerate

  always_comb begin
    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + PW'(1);
  end

  // Once the count saturates the window counts as full.
  assign checked = !((CW'(count_nxt) < CW'(len)) && (count_nxt != COUNT_MAX));
  assign hit     = checked && (&cell_ok);
  assign diff    = CW'(count_nxt) - CW'(len);
  assign pos     = (count_nxt == COUNT_MAX) ? COUNT_MAX : diff[PW-1:0];

  logic [sfm_pkg::OUT_POS_W-1:0] pos_out;
  generate
    if (PW >= sfm_pkg::OUT_POS_W) begin : g_pos_trunc
      assign pos_out = pos[sfm_pkg::OUT_POS_W-1:0];
    end else begin : g_pos_ext
      assign pos_out = {{(sfm_pkg::OUT_POS_W-PW){1'b0}}, pos};
    end
  endgenerate

  logic [PW-1:0] count_upd;

  always_comb begin
    count_upd     = count_r;
    given_nxt     = given_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    if (accept) begin
      if (is_zero) begin
        if (!given_r) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = (len == '0);
          out_pos_nxt   = '0;
        end
        count_upd = '0;
        given_nxt = 1'b0;
      end else if (!given_r) begin
        if (len == '0) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_pos_nxt   = '0;
          given_nxt     = 1'b1;
        end else begin
          count_upd = count_nxt;
          if (hit) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b1;
            out_pos_nxt   = pos_out;
            given_nxt     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      given_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_upd;
      given_r     <= given_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_match_position = out_pos_r;

endmodule
